>>> design/svtt_pkg.sv
package svtt_pkg;

  // Field widths
  localparam int VOLT_W = 21;
  localparam int TEMP_W = 15;

  // Table geometry
  localparam int TBL_LEN      = 21;
  localparam int IDX_W        = 5;
  localparam int SEARCH_STEPS = 5;
  localparam int STEP_CNT_W   = 3;

  // Interpolation arithmetic
  localparam int SLOPE_W    = 13;  // slopes in uV/C, below 8192
  localparam int DIFF_W     = 16;  // voltage offset inside one segment, below 65536
  localparam int SCALED_W   = 23;  // offset times 100
  localparam int BASE_W     = 16;  // segment base temperature in 0.01 C
  localparam int PROD_W     = 30;
  localparam int NUM_W      = 28;  // signed numerator
  localparam int MAG_W      = NUM_W - 1;
  localparam int DIV_CNT_W  = 5;

  localparam logic [BASE_W-1:0]  CENTI_PER_STEP = 16'd1000;
  localparam logic [BASE_W-1:0]  CENTI_BASE     = 16'd5000;
  localparam logic [6:0]         CENTI          = 7'd100;

  localparam logic [VOLT_W-1:0] VOLT_TBL [TBL_LEN] = '{
    21'd1350441, 21'd1300593, 21'd1250398, 21'd1199884, 21'd1149070,
    21'd1097987, 21'd1046647, 21'd995050,  21'd943227,  21'd891178,
    21'd838882,  21'd786360,  21'd733608,  21'd680654,  21'd627490,
    21'd574117,  21'd520551,  21'd466760,  21'd412739,  21'd358164,
    21'd302785
  };

  localparam logic [SLOPE_W-1:0] SLOPE_TBL [TBL_LEN] = '{
    13'd4985, 13'd5020, 13'd5051, 13'd5081, 13'd5108,
    13'd5134, 13'd5160, 13'd5182, 13'd5205, 13'd5230,
    13'd5252, 13'd5275, 13'd5295, 13'd5316, 13'd5337,
    13'd5357, 13'd5379, 13'd5402, 13'd5458, 13'd5538,
    13'd5538
  };

  localparam logic [VOLT_W-1:0] VOLT_TOP    = VOLT_TBL[0];
  localparam logic [VOLT_W-1:0] VOLT_BOTTOM = VOLT_TBL[TBL_LEN-1];

  // Table reads; indexes past the end read as zero
  function automatic logic [VOLT_W-1:0] volt_at(input logic [IDX_W-1:0] idx);
    logic [VOLT_W-1:0] v;
    v = '0;
    if (int'(idx) < TBL_LEN) begin
      v = VOLT_TBL[idx];
    end
    return v;
  endfunction

  function automatic logic [SLOPE_W-1:0] slope_at(input logic [IDX_W-1:0] idx);
    logic [SLOPE_W-1:0] s;
    s = '0;
    if (int'(idx) < TBL_LEN) begin
      s = SLOPE_TBL[idx];
    end
    return s;
  endfunction

endpackage

>>> design/svtt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module svtt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [svtt_pkg::MAG_W-1:0]    dividend,
  input  logic [svtt_pkg::SLOPE_W-1:0]  divisor,
  output logic                          done,
  output logic [svtt_pkg::TEMP_W-1:0]   quotient
);
  import svtt_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SLOPE_W-1:0]   den;
  logic [SLOPE_W-1:0]   rem;
  logic [MAG_W-1:0]     dq;     // dividend bits shift out, quotient bits shift in

  logic [SLOPE_W:0]     rem_sh;
  logic [SLOPE_W:0]     rem_sub;
  logic                 q_bit;

  // trial subtract
  always_comb begin
    rem_sh  = {rem, dq[MAG_W-1]};
    rem_sub = rem_sh - {1'b0, den};
    q_bit   = (rem_sh >= {1'b0, den});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= q_bit ? rem_sub[SLOPE_W-1:0] : rem_sh[SLOPE_W-1:0];
      dq  <= {dq[MAG_W-2:0], q_bit};
    end
  end

  assign quotient = dq[TEMP_W-1:0];

endmodule

>>> design/sensor_voltage_to_temperature.sv
// Converts a sensor voltage in microvolts to temperature in 0.01 C by piecewise-linear
// interpolation over a 21-point table (-50 C to +150 C in 10 C steps), truncated toward
// zero. Voltages outside the table span give 0 with out_of_range set. One word is worked
// on at a time: an in-range word passes through 5 binary-search steps, the multiply and
// sum states that form the numerator, the bit-serial divider that sets the rate, and the
// hand-off of the result; an out-of-range word goes straight to the hand-off. The result
// sits in an output register, so the next word is accepted while a result still waits to
// be taken.
module sensor_voltage_to_temperature (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                voltage_valid,
  output logic                                voltage_stall,
  input  logic [svtt_pkg::VOLT_W-1:0]         voltage_uv,
  output logic                                temp_valid,
  input  logic                                temp_stall,
  output logic signed [svtt_pkg::TEMP_W-1:0]  temp_centi,
  output logic                                out_of_range
);
  import svtt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]              state;
  logic [VOLT_W-1:0]       voltage;
  logic [IDX_W-1:0]        lo;
  logic [IDX_W-1:0]        hi;
  logic [STEP_CNT_W-1:0]   step;
  logic [SLOPE_W-1:0]      slope;
  logic signed [PROD_W-1:0] prod;
  logic [SCALED_W-1:0]     scaled;
  logic                    neg;
  logic [TEMP_W-1:0]       res_temp;
  logic                    res_oor;

  logic                    in_take;
  logic                    out_free;
  logic                    in_range;
  logic [IDX_W-1:0]        mid;
  logic [IDX_W-1:0]        idx;
  logic [VOLT_W-1:0]       seg_diff;
  logic signed [BASE_W-1:0] base_centi;
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0]        mag;
  logic                    div_done;
  logic [TEMP_W-1:0]       div_q;

  assign voltage_stall = (state != ST_IDLE);
  assign in_take       = voltage_valid && !voltage_stall;
  assign out_free      = !temp_valid || !temp_stall;
  assign in_range      = (voltage_uv <= VOLT_TOP) && (voltage_uv >= VOLT_BOTTOM);

  // search midpoint and segment terms
  always_comb begin
    mid        = IDX_W'((6'(lo) + 6'(hi)) >> 1);
    idx        = lo - 1'b1;  // last entry at or above the voltage
    seg_diff   = volt_at(idx) - voltage;
    base_centi = $signed(BASE_W'(idx) * CENTI_PER_STEP - CENTI_BASE);
    num        = prod[NUM_W-1:0] + $signed(NUM_W'(scaled));
    // magnitude goes straight into the divider at its start
    mag        = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= in_range ? ST_SEARCH : ST_DONE;
          end
        end
        ST_SEARCH: begin
          if (step == STEP_CNT_W'(SEARCH_STEPS - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:  state <= ST_SUM;
        ST_SUM:  state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        voltage  <= voltage_uv;
        lo       <= '0;
        hi       <= IDX_W'(TBL_LEN);
        step     <= '0;
        res_temp <= '0;
        res_oor  <= !in_range;
      end
      ST_SEARCH: begin
        step <= step + 1'b1;
        if (lo < hi) begin
          if (volt_at(mid) >= voltage) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
        end
      end
      ST_MUL: begin
        slope  <= slope_at(idx);
        prod   <= base_centi * $signed({1'b0, slope_at(idx)});
        scaled <= SCALED_W'(seg_diff[DIFF_W-1:0]) * SCALED_W'(CENTI);
      end
      ST_SUM: begin
        neg <= num[NUM_W-1];
      end
      ST_DIV: begin
        if (div_done) begin
          res_temp <= neg ? TEMP_W'(-div_q) : div_q;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      temp_valid <= 1'b1;
    end else if (!temp_stall) begin
      temp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      temp_centi   <= $signed(res_temp);
      out_of_range <= res_oor;
    end
  end

  svtt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_SUM),
    .dividend (mag),
    .divisor  (slope),
    .done     (div_done),
    .quotient (div_q)
  );

  // checks
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    temp_valid && out_of_range |-> temp_centi == '0)
    else $error("out-of-range word carries nonzero temperature");

  a_temp_span: assert property (@(posedge clk) disable iff (rst)
    temp_valid && !out_of_range |->
      (temp_centi >= -15'sd5000) && (temp_centi <= 15'sd15000))
    else $error("temperature outside table span");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide phase");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_SEARCH) || (state == ST_DONE))
    else $error("accepted word did not start a conversion");

endmodule

>>> sim/sensor_voltage_to_temperature_tb.sv
`timescale 1ns / 1ps

module sensor_voltage_to_temperature_tb;
  import svtt_pkg::VOLT_W;
  import svtt_pkg::TEMP_W;

  localparam int N_POINTS    = 21;
  localparam int N_RANDOM    = 1100;
  localparam int IDLE_LIMIT  = 5000;   // cycles with no word moving on either side
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_AT     = 300;    // result count at which the long stall starts
  localparam int HOLD_CYCLES = 400;

  // Sensor curve: output in uV at -50 C .. +150 C, and slope in uV/C per segment
  localparam int LEVEL_UV [N_POINTS] = '{
    1350441, 1300593, 1250398, 1199884, 1149070,
    1097987, 1046647,  995050,  943227,  891178,
     838882,  786360,  733608,  680654,  627490,
     574117,  520551,  466760,  412739,  358164,
     302785
  };
  localparam int SLOPE_UV [N_POINTS] = '{
    4985, 5020, 5051, 5081, 5108,
    5134, 5160, 5182, 5205, 5230,
    5252, 5275, 5295, 5316, 5337,
    5357, 5379, 5402, 5458, 5538,
    5538
  };
  localparam logic [VOLT_W-1:0] VOLT_ALL_ONES = '1;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } reading_t;

  // Predicts each reading from its voltage and checks results in order
  class temp_checker;
    reading_t pending_temps[$];
    int       errors = 0;

    function reading_t expected_temp(input logic [VOLT_W-1:0] v);
      reading_t r;
      int       hits;
      int       seg;
      longint   num;
      longint   slope;
      longint   mag;
      r.temp = '0;
      r.oor  = 1'b0;
      if (int'(v) > LEVEL_UV[0] || int'(v) < LEVEL_UV[N_POINTS-1]) begin
        r.oor = 1'b1;
      end else begin
        // segment = last table point at or above the voltage
        hits = 0;
        for (int k = 0; k < N_POINTS; k++) begin
          if (LEVEL_UV[k] >= int'(v)) hits++;
        end
        seg   = hits - 1;
        slope = SLOPE_UV[seg];
        num   = (longint'(seg) * 10 - 50) * 100 * slope
              + 100 * (longint'(LEVEL_UV[seg]) - longint'(v));
        // truncate toward zero
        mag = (num < 0) ? -num : num;
        mag = mag / slope;
        if (num < 0) mag = -mag;
        r.temp = mag[TEMP_W-1:0];
      end
      return r;
    endfunction

    function void note_voltage(input logic [VOLT_W-1:0] v);
      pending_temps.push_back(expected_temp(v));
    endfunction

    function void check_temp(input logic signed [TEMP_W-1:0] temp, input logic oor);
      reading_t want;
      if (pending_temps.size() == 0) begin
        $error("unexpected word: temp_centi %0d out_of_range %0b", temp, oor);
        errors++;
        return;
      end
      want = pending_temps.pop_front();
      if (temp !== want.temp) begin
        $error("temp_centi: expected %0d, got %0d", want.temp, temp);
        errors++;
      end
      if (oor !== want.oor) begin
        $error("out_of_range: expected %0b, got %0b", want.oor, oor);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     voltage_valid = 1'b0;
  logic                     voltage_stall;
  logic [VOLT_W-1:0]        voltage_uv = '0;
  logic                     temp_valid;
  logic                     temp_stall = 1'b0;
  logic signed [TEMP_W-1:0] temp_centi;
  logic                     out_of_range;

  temp_checker readings = new();
  int          idle_cycles = 0;

  sensor_voltage_to_temperature DUT (
    .clk           (clk),
    .rst           (rst),
    .voltage_valid (voltage_valid),
    .voltage_stall (voltage_stall),
    .voltage_uv    (voltage_uv),
    .temp_valid    (temp_valid),
    .temp_stall    (temp_stall),
    .temp_centi    (temp_centi),
    .out_of_range  (out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor both channels; watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (!rst) begin
      if (voltage_valid && !voltage_stall) readings.note_voltage(voltage_uv);
      if (temp_valid && !temp_stall) readings.check_temp(temp_centi, out_of_range);
      if ((voltage_valid && !voltage_stall) || (temp_valid && !temp_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one voltage word after a gap, hold it until taken
  task automatic send_voltage(input logic [VOLT_W-1:0] v, input int gap);
    if (gap > 0) begin
      voltage_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    voltage_valid <= 1'b1;
    voltage_uv    <= v;
    @(posedge clk);
    while (voltage_stall) @(posedge clk);
  endtask

  function automatic logic [VOLT_W-1:0] random_voltage();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      v = $urandom_range(LEVEL_UV[N_POINTS-1], LEVEL_UV[0]);
    end else if (pick < 8) begin
      // close to a table point, either side
      v = LEVEL_UV[$urandom_range(0, N_POINTS-1)] + $urandom_range(0, 8) - 4;
    end else begin
      v = $urandom_range(0, int'(VOLT_ALL_ONES));
    end
    return v[VOLT_W-1:0];
  endfunction

  // Draw a sender gap; every third stretch of 100 words runs back to back
  function automatic int draw_gap(input int n);
    return ((n / 100) % 3 == 1) ? 0 : $urandom_range(0, 14);
  endfunction

  // Result side: random stall per word, every third stretch of 80 words unstalled, one long hold to back the block up
  initial begin
    int taken;
    int hold;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) hold = HOLD_CYCLES;
      else if ((taken / 80) % 3 == 2) hold = 0;
      else hold = $urandom_range(0, 14);
      if (hold > 0) begin
        temp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      temp_stall <= 1'b0;
      @(posedge clk);
      while (!temp_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: every table point, both edges of the span, field extremes
    n = 0;
    for (int k = 0; k < N_POINTS; k++) begin
      send_voltage(VOLT_W'(LEVEL_UV[k]), draw_gap(n));
      n++;
    end
    send_voltage(VOLT_W'(LEVEL_UV[0] + 1), draw_gap(n));
    n++;
    send_voltage(VOLT_W'(LEVEL_UV[N_POINTS-1] - 1), draw_gap(n));
    n++;
    send_voltage('0, draw_gap(n));
    n++;
    send_voltage(VOLT_ALL_ONES, draw_gap(n));
    n++;

    for (int i = 0; i < N_RANDOM; i++) begin
      send_voltage(random_voltage(), draw_gap(n));
      n++;
    end
    voltage_valid <= 1'b0;

    while (readings.pending_temps.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (readings.errors == 0 && readings.pending_temps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
